>>> rtl/core/lzss4k_pkg.sv
// Shared constants and the command type for the 4k-window LZSS decoder.
package lzss4k_pkg;

    // History window; must be a power of two so pointers wrap by truncation.
    localparam int HISTORY_SIZE = 4096;
    localparam int HIST_AW      = $clog2(HISTORY_SIZE);

    // Command queue between the stream parser and the copy engine.
    localparam int CMD_Q_DEPTH  = 4;
    localparam int CMD_Q_AW     = $clog2(CMD_Q_DEPTH);

    // One decoded token: a literal (byte in word[7:0]) or a reference
    // (little-endian word: length-3 in [3:0], distance in [15:4]).
    typedef struct packed {
        logic        is_ref;
        logic [15:0] word;
    } cmd_t;

endpackage

>>> rtl/core/lzss4k_front.sv
// Stream parser: tracks flag bytes and token phases, emits literal/reference commands.
module lzss4k_front import lzss4k_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_stall,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    typedef enum logic [2:0] {
        PH_FLAG     = 3'b001,
        PH_TOKEN    = 3'b010,
        PH_REF_HIGH = 3'b100
    } phase_t;

    localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;

    phase_t     phase_reg, phase_next;
    logic [7:0] flag_bits_reg, flag_bits_next;
    logic [3:0] tokens_left_reg, tokens_left_next;
    logic [7:0] ref_low_reg, ref_low_next;
    logic [3:0] tokens_dec;
    logic       accept;
    logic       token_done;

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign tokens_dec = (tokens_left_reg != 4'd0) ? tokens_left_reg - 4'd1 : 4'd0;

    always_comb
    begin
        phase_next       = phase_reg;
        flag_bits_next   = flag_bits_reg;
        tokens_left_next = tokens_left_reg;
        ref_low_next     = ref_low_reg;
        push             = 1'b0;
        push_cmd.is_ref  = 1'b0;
        push_cmd.word    = {8'h00, in_byte};
        token_done       = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                PH_FLAG:
                begin
                    flag_bits_next   = in_byte;
                    tokens_left_next = TOKENS_PER_FLAG;
                    phase_next       = PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    if (flag_bits_reg[0])
                    begin
                        push       = 1'b1;
                        token_done = 1'b1;
                    end
                    else
                    begin
                        ref_low_next = in_byte;
                        phase_next   = PH_REF_HIGH;
                    end
                end
                PH_REF_HIGH:
                begin
                    push            = 1'b1;
                    push_cmd.is_ref = 1'b1;
                    push_cmd.word   = {in_byte, ref_low_reg};
                    token_done      = 1'b1;
                end
                default:
                begin
                    phase_next = PH_FLAG;
                end
            endcase
        end

        if (token_done)
        begin
            flag_bits_next   = flag_bits_reg >> 1;
            tokens_left_next = tokens_dec;
            phase_next       = (tokens_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_FLAG;
            flag_bits_reg   <= 8'h00;
            tokens_left_reg <= 4'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            flag_bits_reg   <= flag_bits_next;
            tokens_left_reg <= tokens_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_low_reg <= ref_low_next;
    end

endmodule

>>> rtl/core/lzss4k_cmd_q.sv
// Small command FIFO decoupling the parser from the copy engine.
module lzss4k_cmd_q import lzss4k_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic not_empty
);

    cmd_t                q_mem_reg [CMD_Q_DEPTH];
    logic [CMD_Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_Q_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == (CMD_Q_AW+1)'(CMD_Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + CMD_Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + CMD_Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (CMD_Q_AW+1)'(do_push) - (CMD_Q_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/lzss4k_back.sv
// Copy engine: history RAM, byte-per-cycle copy pipeline (paused while the output stalls) and output register.
module lzss4k_back import lzss4k_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } state_t;

    localparam int             LEN_W    = 5;
    localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(3);

    logic [7:0]         hist_mem [HISTORY_SIZE];

    state_t             state_reg, state_next;
    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic               wrapped_reg, wrapped_next;
    logic [HIST_AW-1:0] src_reg, src_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;

    // pending byte: read data arrives in the cycle after issue
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_ovr_reg, pend_ovr_next;
    logic [7:0]         pend_ovr_data_reg, pend_ovr_data_next;
    logic               pend_known_reg, pend_known_next;
    logic               pend_last_reg, pend_last_next;
    logic [7:0]         rd_data_reg;
    logic [7:0]         pend_byte;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;

    logic               advance, pend_fire, issue_rd, issue_lit;
    logic [HIST_AW-1:0] wp_eff, ref_dist;

    assign pend_byte = pend_ovr_reg ? pend_ovr_data_reg
                                    : (pend_known_reg ? rd_data_reg : 8'h00);
    assign advance   = !out_valid_reg || !out_stall;
    assign pend_fire = pend_valid_reg && advance;
    // write pointer once any pending byte has retired, stalled or not
    assign wp_eff    = wp_reg + HIST_AW'(pend_valid_reg);
    assign ref_dist  = HIST_AW'(cmd.word[15:4]);

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        cnt_next   = cnt_reg;
        cmd_pop    = 1'b0;
        issue_rd   = 1'b0;
        issue_lit  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_ref)
                    begin
                        cmd_pop    = 1'b1;
                        src_next   = wp_eff - ref_dist;
                        cnt_next   = LEN_W'(cmd.word[3:0]) + LEN_BIAS;
                        state_next = ST_COPY;
                    end
                    else if (advance)
                    begin
                        cmd_pop   = 1'b1;
                        issue_lit = 1'b1;
                    end
                end
            end
            ST_COPY:
            begin
                if (advance)
                begin
                    issue_rd = 1'b1;
                    src_next = src_reg + HIST_AW'(1);
                    cnt_next = cnt_reg - LEN_W'(1);
                    if (cnt_reg == LEN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_valid_next    = pend_valid_reg;
        pend_ovr_next      = pend_ovr_reg;
        pend_ovr_data_next = pend_ovr_data_reg;
        pend_known_next    = pend_known_reg;
        pend_last_next     = pend_last_reg;

        if (issue_lit)
        begin
            pend_valid_next    = 1'b1;
            pend_ovr_next      = 1'b1;
            pend_ovr_data_next = cmd.word[7:0];
            pend_known_next    = 1'b1;
            pend_last_next     = 1'b1;
        end
        else if (issue_rd)
        begin
            // bypass when the read hits the slot being written this cycle
            pend_valid_next    = 1'b1;
            pend_ovr_next      = pend_valid_reg && (src_reg == wp_reg);
            pend_ovr_data_next = pend_byte;
            // slots not yet reached by the write pointer still read as zero
            pend_known_next    = wrapped_reg || (src_reg < wp_reg);
            pend_last_next     = (cnt_reg == LEN_W'(1));
        end
        else if (pend_fire)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        out_valid_next = out_valid_reg;
        if (pend_fire)
        begin
            wp_next        = wp_reg + HIST_AW'(1);
            out_valid_next = 1'b1;
            if (wp_reg == '1)
            begin
                wrapped_next = 1'b1;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            wrapped_reg    <= wrapped_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg           <= src_next;
        cnt_reg           <= cnt_next;
        pend_ovr_reg      <= pend_ovr_next;
        pend_ovr_data_reg <= pend_ovr_data_next;
        pend_known_reg    <= pend_known_next;
        pend_last_reg     <= pend_last_next;
        if (pend_fire)
        begin
            out_byte_reg <= pend_byte;
            out_last_reg <= pend_last_reg;
        end
    end

    // history RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pend_fire)
        begin
            hist_mem[wp_reg] <= pend_byte;
        end
        if (issue_rd)
        begin
            rd_data_reg <= hist_mem[src_reg];
        end
    end

endmodule

>>> rtl/core/lzss_decoder_4k_window.sv
// Top level of the LZSS decoder with a 4096-byte history window.
//
// Input channel (in_valid / in_stall / in_byte): one compressed byte per
// transaction. Flag bytes and reference low bytes produce no output.
// Output channel (out_valid / out_stall / out_byte / last_of_run): one
// decompressed byte per transaction; last_of_run marks the final byte
// caused by one input byte (a literal gives one, a reference 3 to 18).
// A literal passes the command queue, the pending-byte registers and the
// output register; a reference byte also reads the history RAM first.
// Throughput, while out_stall is low: literals run at one byte per cycle;
// a reference copies at that rate once popped, bound by the RAM read port.
// A 4-entry command queue lets the parser keep taking input during copies.
// Reset: parser expects a flag byte, write pointer at zero. The history is
// not swept; a fill mark makes unwritten slots read as zero, so the block
// is ready as soon as reset is released.
// When the receiver stalls, the output register holds, the copy engine
// pauses, and once the queue fills in_stall is raised.
module lzss_decoder_4k_window import lzss4k_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    cmd_t q_pop_cmd;
    logic q_not_empty;

    // parser: flag bytes and token phases
    lzss4k_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_stall (in_stall),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    // decoded tokens wait here for the copy engine
    lzss4k_cmd_q u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (q_pop_cmd),
        .not_empty (q_not_empty)
    );

    // copy engine with history RAM and output register
    lzss4k_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_not_empty),
        .cmd         (q_pop_cmd),
        .cmd_pop     (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
